// File: rtl/xlab_pkg.sv
// xlab_pkg: shared constants, types and elaboration-time lookup tables
// for the XYZ to CIELAB converter. No dependencies.
package xlab_pkg;

    // fixed-point format of the f() values
    localparam int FRAC_BITS = 20;
    localparam int FW        = FRAC_BITS + 1;   // f spans 0..1.0 inclusive
    localparam int SW        = FRAC_BITS + 11;  // signed pre-rounding sums
    localparam int QW        = 10;              // rounded magnitude, up to 500

    // field widths
    localparam int IN_W      = 7;
    localparam int L_W       = 7;
    localparam int A_W       = 10;
    localparam int B_W       = 9;
    localparam int TAB_DEPTH = 1 << IN_W;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((3 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((L_W + A_W + B_W + 7) / 8) * 8;

    // channel limits and white point (times 100)
    localparam int X_MAX  = 95;
    localparam int Y_MAX  = 100;
    localparam int Z_MAX  = 108;
    localparam int WX100  = 9505;
    localparam int WY100  = 10000;
    localparam int WZ100  = 10890;
    localparam int L_MAX  = 100;

    typedef logic [FW-1:0]        fix_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [QW:0]   rnd_t;
    typedef logic [127:0]         wide_t;
    typedef fix_t                 f_table_t [TAB_DEPTH];

    // restoring division, used at elaboration only
    function automatic wide_t wide_div(input wide_t num, input wide_t den);
        wide_t rem;
        wide_t quo;
        rem = '0;
        quo = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[126:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // f(v / (w100/100)) rounded to nearest, FRAC_BITS fraction bits
    function automatic fix_t lab_f(input int v, input int w100);
        wide_t rhs;
        wide_t lhs;
        wide_t c;
        wide_t d;
        wide_t r;
        wide_t num;
        wide_t den;
        r = '0;
        if (wide_t'(v) * wide_t'(100000000) > wide_t'(8856) * wide_t'(w100)) begin
            rhs = wide_t'(800 * v) << (3 * FRAC_BITS);
            for (int bit_pos = FRAC_BITS; bit_pos >= 0; bit_pos--) begin
                c   = r | (wide_t'(1) << bit_pos);
                d   = (c << 1) - wide_t'(1);
                lhs = d * d * d * wide_t'(w100);
                if (lhs <= rhs)
                    r = c;
            end
        end else begin
            num = wide_t'(7787 * 100 * 116) * wide_t'(v)
                + wide_t'(16000) * wide_t'(w100);
            den = wide_t'(116000) * wide_t'(w100);
            r   = wide_div((num << FRAC_BITS) + (den >> 1), den);
        end
        return r[FW-1:0];
    endfunction

    // full index range; codes above the channel maximum saturate
    function automatic f_table_t build_table(input int vmax, input int w100);
        f_table_t t;
        for (int v = 0; v < TAB_DEPTH; v++)
            t[v] = lab_f((v > vmax) ? vmax : v, w100);
        return t;
    endfunction

    localparam f_table_t FX_TABLE = build_table(X_MAX, WX100);
    localparam f_table_t FY_TABLE = build_table(Y_MAX, WY100);
    localparam f_table_t FZ_TABLE = build_table(Z_MAX, WZ100);

endpackage

// File: rtl/xlab_round.sv
// xlab_round: rounds a signed fixed-point sum to an integer, half away
// from zero. Depends on xlab_pkg.
module xlab_round (
    input  xlab_pkg::sum_t sum_in,
    output xlab_pkg::rnd_t rnd_out
);
    import xlab_pkg::*;

    logic          neg;
    logic [SW-1:0] mag;
    logic [SW-1:0] biased;
    logic [QW-1:0] qmag;

    assign neg    = sum_in[SW-1];
    assign mag    = neg ? (~sum_in + SW'(1)) : sum_in;
    assign biased = mag + (SW'(1) << (FRAC_BITS - 1));
    assign qmag   = biased[FRAC_BITS +: QW];
    assign rnd_out = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

// File: rtl/xyz_to_lab_converter.sv
// xyz_to_lab_converter: streaming CIE XYZ (D65) to CIELAB converter, top level.
// Depends on xlab_pkg and xlab_round.
//
// Usage
//   Input word on s_* : X, Y, Z integers. Values above 95/100/108 saturate.
//   Output word on m_*: L (0..100), a and b as two's complement integers.
//   Three register stages:
//     1: f(X), f(Y), f(Z) read from constant tables (cube root / linear
//        branch precomputed at elaboration, 20 fraction bits)
//     2: 116*fy-16, 500*(fx-fy), 200*(fy-fz) via constant multipliers
//     3: round half away from zero, clamp L; this is the output register
//   A word passes through stages 1, 2 and 3 in order, and m_tvalid is the
//   stage 3 valid bit. Throughput: one word per clock while m_tready does
//   not stall the output; the constant multiply stage sets the cycle depth.
//   Each stage has its own valid bit and advances when it is empty or the
//   next one moves, so bubbles collapse and the input keeps taking words
//   under a stalled m_tready until all three stages hold one.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers
//   are not reset. Nothing is lost or repeated across stalls.
module xyz_to_lab_converter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] x_value, [13:7] y_value, [20:14] z_value, rest zero
    input  logic [xlab_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] lightness, [16:7] green_red, [25:17] blue_yellow, rest zero
    output logic [xlab_pkg::M_TDATA_W-1:0]    m_tdata
);
    import xlab_pkg::*;

    // stage readies: a stage loads when empty or when it drains
    logic ready1, ready2, ready3;

    // stage 1: f values
    logic v1_reg, v1_next;
    fix_t fx_reg, fy_reg, fz_reg;

    // stage 2: scaled sums before rounding
    logic v2_reg, v2_next;
    sum_t sl_reg, sa_reg, sb_reg;
    sum_t sl_next, sa_next, sb_next;
    sum_t fx_ext, fy_ext, fz_ext;

    // stage 3: output word
    logic            v3_reg, v3_next;
    logic [L_W-1:0]  light_reg, light_next;
    logic [A_W-1:0]  gr_reg, gr_next;
    logic [B_W-1:0]  by_reg, by_next;
    rnd_t            rl, ra, rb;

    logic [IN_W-1:0] x_in, y_in, z_in;

    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    assign x_in = s_tdata[0 +: IN_W];
    assign y_in = s_tdata[IN_W +: IN_W];
    assign z_in = s_tdata[2*IN_W +: IN_W];

    // valid bits
    assign v1_next = ready1 ? s_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: table reads (saturation is built into the tables)
    always_ff @(posedge aclk) begin
        if (s_tvalid && ready1) begin
            fx_reg <= FX_TABLE[x_in];
            fy_reg <= FY_TABLE[y_in];
            fz_reg <= FZ_TABLE[z_in];
        end
    end

    // stage 2: constant multiplies on the fixed-point f values
    assign fx_ext  = $signed({{(SW-FW){1'b0}}, fx_reg});
    assign fy_ext  = $signed({{(SW-FW){1'b0}}, fy_reg});
    assign fz_ext  = $signed({{(SW-FW){1'b0}}, fz_reg});
    assign sl_next = SW'(116) * fy_ext - (SW'(16) <<< FRAC_BITS);
    assign sa_next = SW'(500) * (fx_ext - fy_ext);
    assign sb_next = SW'(200) * (fy_ext - fz_ext);

    always_ff @(posedge aclk) begin
        if (v1_reg && ready2) begin
            sl_reg <= sl_next;
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
    end

    // stage 3: rounding and L clamp
    xlab_round u_round_l (.sum_in(sl_reg), .rnd_out(rl));
    xlab_round u_round_a (.sum_in(sa_reg), .rnd_out(ra));
    xlab_round u_round_b (.sum_in(sb_reg), .rnd_out(rb));

    // black can round a hair below zero
    always_comb begin
        if (rl[QW])
            light_next = '0;
        else if (rl > $signed((QW+1)'(L_MAX)))
            light_next = L_W'(L_MAX);
        else
            light_next = rl[L_W-1:0];
    end
    assign gr_next = ra[A_W-1:0];
    assign by_next = rb[B_W-1:0];

    always_ff @(posedge aclk) begin
        if (v2_reg && ready3) begin
            light_reg <= light_next;
            gr_reg    <= gr_next;
            by_reg    <= by_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_TDATA_W-L_W-A_W-B_W){1'b0}}, by_reg, gr_reg, light_reg};

    // checks
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word did not reach stage 1");

    a_s2_drains_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && ready3 |=> v3_reg)
        else $error("stage 2 word lost on its way out");

    a_light_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> light_reg <= L_W'(L_MAX))
        else $error("lightness out of range");

    a_gr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> ($signed(gr_reg) <= $signed(A_W'(431)))
                && ($signed(gr_reg) >= $signed(-A_W'(431))))
        else $error("green_red out of range");

endmodule
